// ----- rtl/bsrs_pkg.sv -----
`timescale 1ns / 1ps
package bsrs_pkg;

  // Request modes
  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_ERASE    = 2'd1;
  localparam logic [1:0] MODE_CONTAINS = 2'd2;
  localparam logic [1:0] MODE_GET      = 2'd3;

  // Request word
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] item_value;
    logic [5:0]  rank_index;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic        success;
    logic [31:0] found_value;
    logic [6:0]  member_count;
    logic        is_empty;
  } out_word_t;

endpackage

// ----- rtl/bsrs_ram.sv -----
`timescale 1ns / 1ps
module bsrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/bounded_set_rank_select.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_word   (mode, item_value, rank_index)
// out_      output     out_valid/ out_stall out_word  (success, found_value, member_count,
//                                                      is_empty)
// cfg_      input      cfg_wr_en            cfg_wr_data (capacity_limit)
//
// One request at a time; all members live in one single-port-read RAM, one entry per cycle.
// Insert / contains: a linear scan. Erase: scan to the match, then shift each later entry
// down one place. Get: a full counting scan per candidate through the RAM read port.
// Reset (rst_n low, synchronous) empties the set and sets the limit to 64; no clearing pass.
// A stalled result sits in the output register; the next request is taken meanwhile.
module bounded_set_rank_select #(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsrs_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bsrs_pkg::out_word_t  out_word,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data
);
  import bsrs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RCAND = 3'd3;
  localparam logic [2:0] S_RLOAD = 3'd4;
  localparam logic [2:0] S_RSCAN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [6:0]            limit_r, limit_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [1:0]            mode_r, mode_nxt;
  logic [ITEM_WIDTH-1:0] val_r, val_nxt;
  logic [5:0]            rank_r, rank_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]         rd_tag_r, rd_tag_nxt;
  logic [CW-1:0]         cand_idx_r, cand_idx_nxt;
  logic [ITEM_WIDTH-1:0] cand_r, cand_nxt;
  logic [CW-1:0]         smaller_r, smaller_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [31:0]           res_found_r, res_found_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  logic                  hit;
  logic                  scan_end;
  logic                  can_insert;

  bsrs_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // scan status
  assign hit        = rd_pend_r && (ram_rdata == val_r);
  assign scan_end   = !rd_pend_r && (rd_idx_r >= count_r);
  assign can_insert = (LW'(count_r) < LW'(limit_r)) && (count_r < CW'(CAPACITY));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    rank_nxt      = rank_r;
    rd_idx_nxt    = rd_idx_r;
    rd_tag_nxt    = rd_tag_r;
    cand_idx_nxt  = cand_idx_r;
    cand_nxt      = cand_r;
    smaller_nxt   = smaller_r;
    res_ok_nxt    = res_ok_r;
    res_found_nxt = res_found_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt      = in_word.mode;
          val_nxt       = ITEM_WIDTH'(in_word.item_value);
          rank_nxt      = in_word.rank_index;
          rd_idx_nxt    = '0;
          cand_idx_nxt  = '0;
          res_found_nxt = '0;
          res_ok_nxt    = 1'b0;
          if (in_word.mode == MODE_GET) begin
            if (LW'(in_word.rank_index) >= LW'(count_r)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RCAND;
            end
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      // linear search for val_r
      S_FIND: begin
        if (hit) begin
          case (mode_r)
            MODE_ERASE: begin
              rd_idx_nxt = CW'(rd_tag_r) + CW'(1);
              state_nxt  = S_SHIFT;
            end
            MODE_CONTAINS: begin
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (scan_end) begin
          if (mode_r == MODE_INSERT && can_insert) begin
            ram_we     = 1'b1;
            count_nxt  = count_r + CW'(1);
            res_ok_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
          rd_tag_nxt  = rd_idx_r[AW-1:0];
        end
      end

      // close the gap: entry q+1 moves to q, read runs one ahead of write
      S_SHIFT: begin
        if (rd_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_tag_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
          rd_tag_nxt  = rd_idx_r[AW-1:0];
        end else if (!rd_pend_r) begin
          count_nxt  = count_r - CW'(1);
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end
      end

      // fetch the next rank candidate
      S_RCAND: begin
        ram_re    = 1'b1;
        ram_raddr = cand_idx_r[AW-1:0];
        state_nxt = S_RLOAD;
      end

      S_RLOAD: begin
        cand_nxt    = ram_rdata;
        rd_idx_nxt  = '0;
        smaller_nxt = '0;
        state_nxt   = S_RSCAN;
      end

      // count members below the candidate
      S_RSCAN: begin
        if (rd_pend_r && (ram_rdata < cand_r)) begin
          smaller_nxt = smaller_r + CW'(1);
        end
        if (scan_end) begin
          if (LW'(smaller_r) == LW'(rank_r)) begin
            res_ok_nxt    = 1'b1;
            res_found_nxt = 32'(cand_r);
            state_nxt     = S_DONE;
          end else if ((cand_idx_r + CW'(1)) >= count_r) begin
            state_nxt = S_DONE;
          end else begin
            cand_idx_nxt = cand_idx_r + CW'(1);
            state_nxt    = S_RCAND;
          end
        end else if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.success      = res_ok_r;
          out_word_nxt.found_value  = res_found_r;
          out_word_nxt.member_count = 7'(count_r);
          out_word_nxt.is_empty     = (count_r == '0);
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= 7'd64;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    val_r       <= val_nxt;
    rank_r      <= rank_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_tag_r    <= rd_tag_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_r      <= cand_nxt;
    smaller_r   <= smaller_nxt;
    res_ok_r    <= res_ok_nxt;
    res_found_r <= res_found_nxt;
    out_word_r  <= out_word_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("member count above capacity");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_FIND || state_r == S_SHIFT))
    else $error("store written outside insert or shift");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result word appeared without a finished request");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r)))
      |-> ($past(state_r) == S_FIND || $past(state_r) == S_SHIFT))
    else $error("count changed outside insert or erase");

endmodule
